// ===== hw/rtl/dtc_pkg.sv =====
// Shared types and constants for the decision tree classifier.
`default_nettype none
package dtc_pkg;
	localparam logic [1:0] ACT_NODE     = 2'd0;
	localparam logic [1:0] ACT_VAR      = 2'd1;
	localparam logic [1:0] ACT_FEATURE  = 2'd2;
	localparam logic [1:0] ACT_CLASSIFY = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CATEGORY = 2'd1;
	localparam logic [1:0] ST_LIMIT    = 2'd2;

	localparam logic [0:0] REG_PERMUTE_VAR    = 1'd0;
	localparam logic [0:0] REG_PERMUTE_ENABLE = 1'd1;

	localparam int NODE_W = 8;
	localparam int VAR_W  = 6;
	localparam int COL_W  = 8;
	localparam int CAT_MAX = 32;

	// Node entry as stored: left, right, terminal, variable, threshold, mask, label.
	localparam int NODE_ENTRY_W = 8 + 8 + 1 + 6 + 32 + 32 + 8;
	localparam int VAR_ENTRY_W  = 8 + 1;

	typedef struct packed {
		logic [7:0]  left;
		logic [7:0]  right;
		logic        terminal;
		logic [5:0]  variable;
		logic [31:0] threshold;
		logic [31:0] mask;
		logic [7:0]  label;
	} node_t;

	typedef struct packed {
		logic [7:0] column;
		logic       categorical;
	} var_t;

	// One queued command from the front part to the walker.
	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  node_index;
		node_t       node;
		logic [5:0]  variable;
		logic [7:0]  column;
		logic        categorical;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] predicted_class;
		logic [7:0] leaf_node;
		logic [1:0] status;
	} res_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dtc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module dtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/dtc_front.sv =====
// Front part: accepts input transfers and queues them as commands.
`default_nettype none
module dtc_front #(
	parameter int DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire dtc_pkg::cmd_t in_cmd,
	output logic               cmd_valid,
	input  wire logic          cmd_ready,
	output dtc_pkg::cmd_t      cmd
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	dtc_pkg::cmd_t buf_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != (AW+1)'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = buf_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue count overflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count step");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/dtc_walk.sv =====
// Back part: table writes and the tree walk sequencer.
`default_nettype none
module dtc_walk (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire dtc_pkg::cmd_t cmd,
	input  wire logic [5:0]    permute_var,
	input  wire logic          permute_enable,
	output logic               res_valid,
	input  wire logic          res_ready,
	output dtc_pkg::res_t      res
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_NODE = 3'd1;
	localparam logic [2:0] S_VAR  = 3'd2;
	localparam logic [2:0] S_FEAT = 3'd3;
	localparam logic [2:0] S_DEC  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]  state_q;
	logic [7:0]  node_q;
	logic [8:0]  steps_q;
	logic [31:0] pval_q;
	dtc_pkg::node_t nd_q;
	logic [1:0]  status_q;

	dtc_pkg::node_t node_rd;
	dtc_pkg::var_t  var_rd;
	logic [31:0]    feat_rd;
	logic [7:0]     node_raddr, feat_raddr;
	logic [7:0]     next_node;
	logic           take;
	logic           we_node, we_var, we_feat;
	logic           sub;
	logic signed [31:0] x;
	logic signed [15:0] cat;
	logic           left;
	logic           cat_bad;

	assign take    = cmd_valid && cmd_ready;
	assign we_node = take && cmd.action == dtc_pkg::ACT_NODE;
	assign we_var  = take && cmd.action == dtc_pkg::ACT_VAR;
	assign we_feat = take && cmd.action == dtc_pkg::ACT_FEATURE;

	// Fetch the root on start and the chosen child during the decision cycle.
	assign next_node  = left ? nd_q.left : nd_q.right;
	assign node_raddr = (state_q == S_IDLE) ? 8'd0 :
		(state_q == S_DEC) ? next_node : node_q;
	assign feat_raddr = var_rd.column;

	dtc_ram #(.WIDTH(dtc_pkg::NODE_ENTRY_W), .DEPTH(256)) u_node (
		.clk(clk), .we(we_node), .waddr(cmd.node_index), .wdata(cmd.node),
		.raddr(node_raddr), .rdata(node_rd));
	dtc_ram #(.WIDTH(dtc_pkg::VAR_ENTRY_W), .DEPTH(64)) u_var (
		.clk(clk), .we(we_var), .waddr(cmd.variable),
		.wdata({cmd.column, cmd.categorical}), .raddr(nd_q.variable), .rdata(var_rd));
	dtc_ram #(.WIDTH(32), .DEPTH(256)) u_feat (
		.clk(clk), .we(we_feat), .waddr(cmd.column), .wdata(cmd.value),
		.raddr(feat_raddr), .rdata(feat_rd));

	// Truncate toward zero: arithmetic shift, plus one when negative with a fraction.
	assign sub = permute_enable && nd_q.variable == permute_var;
	assign x   = sub ? pval_q : feat_rd;
	assign cat = x[31:16] + 16'((x[31] && x[15:0] != '0) ? 1 : 0);
	assign cat_bad = cat < 16'sd1 || cat > 16'(dtc_pkg::CAT_MAX);
	always_comb begin
		if (var_rd.categorical) begin
			left = nd_q.mask[cat[4:0] - 5'd1];
		end else begin
			left = x <= $signed(nd_q.threshold);
		end
	end

	assign cmd_ready = (state_q == S_IDLE) && !res_valid;

	always_ff @(posedge clk) begin
		if (take) begin
			pval_q <= cmd.value;
		end
		if (state_q == S_NODE) begin
			nd_q <= node_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			node_q    <= '0;
			steps_q   <= '0;
			status_q  <= dtc_pkg::ST_OK;
			res_valid <= 1'b0;
			res       <= '0;
		end else begin
			if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take && cmd.action == dtc_pkg::ACT_CLASSIFY) begin
						node_q   <= '0;
						steps_q  <= '0;
						status_q <= dtc_pkg::ST_OK;
						state_q  <= S_NODE;
					end
				end
				S_NODE: begin
					if (node_rd.terminal) begin
						state_q <= S_OUT;
					end else if (steps_q == 9'd256) begin
						status_q <= dtc_pkg::ST_LIMIT;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_VAR;
					end
				end
				S_VAR: state_q <= S_FEAT;
				S_FEAT: state_q <= S_DEC;
				S_DEC: begin
					if (var_rd.categorical && cat_bad) begin
						status_q <= dtc_pkg::ST_CATEGORY;
						state_q  <= S_OUT;
					end else begin
						node_q  <= next_node;
						steps_q <= steps_q + 1'b1;
						state_q <= S_NODE;
					end
				end
				S_OUT: begin
					res.predicted_class <= (status_q == dtc_pkg::ST_OK) ? nd_q.label : 8'd0;
					res.leaf_node       <= node_q;
					res.status          <= status_q;
					res_valid           <= 1'b1;
					state_q             <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// nd_q is loaded in S_NODE; terminal path reads label from node_rd copy next cycle.
`ifndef SYNTHESIS
	a_out_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.status != 2'd3) else $error("bad status code");
	a_ok_class: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != dtc_pkg::ST_OK) |-> res.predicted_class == 8'd0)
		else $error("class on failed walk");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= 9'd256) else $error("walk counter overrun");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/decision_tree_classify_permuted_top.sv =====
// Top level of the decision tree classifier with one permuted variable.
// Input channel (in_valid/in_ready) carries load and classify transfers:
//   action 0 writes a node, 1 a variable entry, 2 a feature, 3 classifies.
// Output channel (out_valid/out_ready) carries one result per classify:
//   predicted_class, leaf_node and status.
// A two-entry command queue sits between the front and the walker, so the
// front keeps taking transfers while the walker is busy or stalled.
// A classify raises out_valid after the queue, the root read and the result
// register when the root is a leaf; each internal node visited adds three
// chained registered memory reads (node, variable, feature) and the compare.
// The result register holds a finished result until out_ready; the walker
// does not start a new command while it holds one.
// Reset clears control state and the registers permute_var and
// permute_enable; the tables are undefined until written.
// Configuration: APB writes at 0 (permute_var) and 4 (permute_enable); the user must write
// only while the block is idle, which the block itself does not enforce.
`default_nettype none
module decision_tree_classify_permuted_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  node_index,
	input  wire logic [7:0]  left_child,
	input  wire logic [7:0]  right_child,
	input  wire logic        leaf_flag,
	input  wire logic [5:0]  variable,
	input  wire logic signed [31:0] threshold,
	input  wire logic [31:0] category_mask,
	input  wire logic [7:0]  class_label,
	input  wire logic [7:0]  column,
	input  wire logic        categorical,
	input  wire logic signed [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       predicted_class,
	output logic [7:0]       leaf_node,
	output logic [1:0]       status,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	dtc_pkg::cmd_t in_cmd, cmd;
	dtc_pkg::res_t res;
	logic cmd_valid, cmd_ready;
	logic [5:0] permute_var_q;
	logic       permute_enable_q;

	// Pack the input transfer into one command.
	always_comb begin
		in_cmd                = '0;
		in_cmd.action         = action;
		in_cmd.node_index     = node_index;
		in_cmd.node.left      = left_child;
		in_cmd.node.right     = right_child;
		in_cmd.node.terminal  = leaf_flag;
		in_cmd.node.variable  = variable;
		in_cmd.node.threshold = threshold;
		in_cmd.node.mask      = category_mask;
		in_cmd.node.label     = class_label;
		in_cmd.variable       = variable;
		in_cmd.column         = column;
		in_cmd.categorical    = categorical;
		in_cmd.value          = value;
	end

	// Configuration registers; paddr[1:0] is the byte offset.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			permute_var_q    <= '0;
			permute_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (paddr[2])
				dtc_pkg::REG_PERMUTE_VAR:    permute_var_q    <= pwdata[5:0];
				dtc_pkg::REG_PERMUTE_ENABLE: permute_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[2])
			dtc_pkg::REG_PERMUTE_VAR:    prdata = {26'd0, permute_var_q};
			dtc_pkg::REG_PERMUTE_ENABLE: prdata = {31'd0, permute_enable_q};
			default:                     prdata = '0;
		endcase
	end

	dtc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_cmd(in_cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

	dtc_walk u_walk (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd(cmd), .permute_var(permute_var_q), .permute_enable(permute_enable_q),
		.res_valid(out_valid), .res_ready(out_ready), .res(res));

	assign predicted_class = res.predicted_class;
	assign leaf_node       = res.leaf_node;
	assign status          = res.status;
endmodule
`default_nettype wire

// ===== tb/dtc_result_checker.sv =====
// Result checker for the decision tree classifier: tracks the tables, predicts each walk and compares.
`timescale 1ns / 100ps
module dtc_result_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  node_index,
	input  wire logic [7:0]  left_child,
	input  wire logic [7:0]  right_child,
	input  wire logic        leaf_flag,
	input  wire logic [5:0]  variable,
	input  wire logic [31:0] threshold,
	input  wire logic [31:0] category_mask,
	input  wire logic [7:0]  class_label,
	input  wire logic [7:0]  column,
	input  wire logic        categorical,
	input  wire logic [31:0] value,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [7:0]  predicted_class,
	input  wire logic [7:0]  leaf_node,
	input  wire logic [1:0]  status,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output int               errors,
	output int               pending,
	output int               n_walks,
	output int               n_bad_cat,
	output int               n_limit
);
	dtc_pkg::node_t tree_nodes [256];
	dtc_pkg::var_t  var_table [64];
	logic [31:0]    features [256];
	logic [5:0]     swap_var;
	logic           swap_en;
	dtc_pkg::res_t  walk_results [$];

	function automatic dtc_pkg::res_t walk_tree(logic signed [31:0] swap_val);
		dtc_pkg::res_t r;
		int unsigned at, steps;
		logic signed [31:0] x;
		int cat;
		logic go_left;
		dtc_pkg::var_t vinfo;
		r.status = dtc_pkg::ST_OK;
		at = 0;
		for (steps = 0; steps <= 256; steps++) begin
			if (tree_nodes[at].terminal)
				break;
			if (steps >= 256) begin
				r.status = dtc_pkg::ST_LIMIT;
				break;
			end
			vinfo = var_table[tree_nodes[at].variable];
			if (swap_en && tree_nodes[at].variable == swap_var)
				x = swap_val;
			else
				x = features[vinfo.column];
			if (!vinfo.categorical) begin
				go_left = x <= $signed(tree_nodes[at].threshold);
			end else begin
				cat = int'(x) / 65536;
				if (cat < 1 || cat > dtc_pkg::CAT_MAX) begin
					r.status = dtc_pkg::ST_CATEGORY;
					break;
				end
				go_left = tree_nodes[at].mask[cat - 1];
			end
			at = go_left ? tree_nodes[at].left : tree_nodes[at].right;
		end
		r.predicted_class = (r.status == dtc_pkg::ST_OK) ? tree_nodes[at].label : 8'd0;
		r.leaf_node = at[7:0];
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		n_walks = 0;
		n_bad_cat = 0;
		n_limit = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		dtc_pkg::res_t want;
		if (!arst_n) begin
			swap_var = '0;
			swap_en = 1'b0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == dtc_pkg::REG_PERMUTE_ENABLE)
					swap_en = pwdata[0];
				else
					swap_var = pwdata[5:0];
			end
			if (out_valid && out_ready) begin
				if (walk_results.size() == 0) begin
					report("unexpected result", 1, 0);
				end else begin
					want = walk_results.pop_front();
					if (predicted_class !== want.predicted_class)
						report("predicted_class", predicted_class, want.predicted_class);
					if (leaf_node !== want.leaf_node)
						report("leaf_node", leaf_node, want.leaf_node);
					if (status !== want.status)
						report("status", status, want.status);
				end
			end
			if (in_valid && in_ready) begin
				case (action)
					dtc_pkg::ACT_NODE: tree_nodes[node_index] = '{left_child, right_child,
						leaf_flag, variable, threshold, category_mask, class_label};
					dtc_pkg::ACT_VAR: var_table[variable] = '{column, categorical};
					dtc_pkg::ACT_FEATURE: features[column] = value;
					dtc_pkg::ACT_CLASSIFY: begin
						want = walk_tree(value);
						walk_results.push_back(want);
						n_walks++;
						if (want.status == dtc_pkg::ST_CATEGORY)
							n_bad_cat++;
						if (want.status == dtc_pkg::ST_LIMIT)
							n_limit++;
					end
					default: ;
				endcase
			end
			pending = walk_results.size();
		end
	end
endmodule

// ===== tb/decision_tree_classify_permuted_top_tb.sv =====
// Stimulus and verdict for the decision tree classifier with one permuted variable.
`timescale 1ns / 100ps
module decision_tree_classify_permuted_top_tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = '0;
	logic [7:0]  node_index = '0;
	logic [7:0]  left_child = '0;
	logic [7:0]  right_child = '0;
	logic        leaf_flag = 1'b0;
	logic [5:0]  variable = '0;
	logic [31:0] threshold = '0;
	logic [31:0] category_mask = '0;
	logic [7:0]  class_label = '0;
	logic [7:0]  column = '0;
	logic        categorical = 1'b0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  predicted_class;
	logic [7:0]  leaf_node;
	logic [1:0]  status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int errors, pending, n_walks, n_bad_cat, n_limit;

	// Traffic knobs for the sender, receiver and main sequence, plus watchdog and item counters.
	bit idle_on = 1'b0;
	bit long_hold = 1'b0;
	int stall_count = 0;
	int cur_swap_var = 0;
	int n_items = 0;

	always #1 clk = ~clk;

	decision_tree_classify_permuted_top dut (.*);

	dtc_result_checker chk (.*);

	// Watchdog: count cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= 20000) begin
			$display("timeout: no transfer for %0d cycles", stall_count);
			$display("** decision_tree_classify_permuted_top: FAILED **");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				long_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Mix of full-range, category-like, small and extreme Q16.16 values.
	function automatic logic [31:0] pick_q();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return (($urandom_range(0, 35) - 1) <<< 16) + $urandom_range(0, 65535);
			2: return $urandom_range(0, 511) - 256;
			default: case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0;
				default: return 32'hFFFF_FFFF;
			endcase
		endcase
	endfunction

	// Present one transfer and hold it until accepted; fields keep their low bits.
	task automatic send(input logic [31:0] act, idx, lc, rc, lf, vr, thr, msk, lbl,
			col, cat, val);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		action <= act[1:0];
		node_index <= idx[7:0];
		left_child <= lc[7:0];
		right_child <= rc[7:0];
		leaf_flag <= lf[0];
		variable <= vr[5:0];
		threshold <= thr;
		category_mask <= msk;
		class_label <= lbl[7:0];
		column <= col[7:0];
		categorical <= cat[0];
		value <= val;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		n_items++;
	endtask

	task automatic put_node(input logic [31:0] idx, lc, rc, lf, vr, thr, msk, lbl);
		send(32'(dtc_pkg::ACT_NODE), idx, lc, rc, lf, vr, thr, msk, lbl,
			$urandom, $urandom, $urandom);
	endtask

	task automatic put_var(input logic [31:0] vr, col, cat);
		send(32'(dtc_pkg::ACT_VAR), $urandom, $urandom, $urandom, $urandom, vr, $urandom,
			$urandom, $urandom, col, cat, $urandom);
	endtask

	task automatic put_feature(input logic [31:0] col, val);
		send(32'(dtc_pkg::ACT_FEATURE), $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, col, $urandom, val);
	endtask

	task automatic classify(input logic [31:0] val);
		send(32'(dtc_pkg::ACT_CLASSIFY), $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom, val);
	endtask

	// Drain all results, let the walker settle, then write one register.
	task automatic write_reg(input logic [31:0] idx, input logic [31:0] data);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx[0], 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx[0] == dtc_pkg::REG_PERMUTE_VAR)
			cur_swap_var = int'(data[5:0]);
	endtask

	// Random tree, mostly of complete binary shape, rooted at node 0, with its variables and features.
	task automatic grow_tree();
		int vars [4];
		int n_int;
		n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
		foreach (vars[k]) begin
			vars[k] = ($urandom_range(0, 2) == 0) ? cur_swap_var : $urandom_range(0, 63);
			put_var(vars[k], $urandom, $urandom_range(0, 1));
		end
		for (int i = 0; i < 2 * n_int + 1; i++) begin
			if (i < n_int)
				put_node(i, ($urandom_range(0, 15) == 0) ? $urandom : 2 * i + 1,
					($urandom_range(0, 15) == 0) ? $urandom : 2 * i + 2, 0,
					vars[$urandom_range(0, 3)], pick_q(), $urandom, $urandom);
			else
				put_node(i, $urandom, $urandom, 1, $urandom, $urandom, $urandom, $urandom);
		end
		repeat (4) put_feature($urandom, pick_q());
	endtask

	task automatic random_phase(input int budget);
		int stop;
		stop = n_items + budget;
		while (n_items < stop) begin
			if ($urandom_range(0, 2) == 0)
				grow_tree();
			repeat ($urandom_range(4, 14)) begin
				case ($urandom_range(0, 9))
					0: put_feature($urandom, pick_q());
					1: send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
					default: classify(pick_q());
				endcase
			end
		end
	endtask

	initial begin
		logic [31:0] cat_vals [6];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every table entry so no walk ever reads an unwritten location.
		for (int i = 0; i < 256; i++)
			put_node(i, $urandom, $urandom, 1, $urandom, $urandom, $urandom, $urandom);
		for (int i = 0; i < 64; i++)
			put_var(i, $urandom, $urandom_range(0, 1));
		for (int i = 0; i < 256; i++)
			put_feature(i, $urandom);

		// Directed: numeric split on var 1 (column 5), leaves 1 and 2.
		put_node(1, 0, 0, 1, 0, 0, 0, 'h11);
		put_node(2, 0, 0, 1, 0, 0, 0, 'hEE);
		put_var(1, 5, 0);
		put_var(2, 6, 1);
		put_node(0, 1, 2, 0, 1, 32'h0, 0, 'h55);
		put_feature(5, 32'h0);
		classify(0);
		put_feature(5, 32'h1);
		classify(0);
		put_node(0, 1, 2, 0, 1, 32'h7FFF_FFFF, 0, 'h55);
		put_feature(5, 32'h7FFF_FFFF);
		classify(0);
		put_node(0, 1, 2, 0, 1, 32'h8000_0000, 0, 'h55);
		put_feature(5, 32'h8000_0000);
		classify(0);
		// Categorical split on var 2: first and last category left, others right,
		// categories below one and above the limit stop the walk.
		put_node(0, 1, 2, 0, 2, 0, 32'h8000_0001, 'h55);
		cat_vals = '{32'h0001_0000, 32'h0020_8000, 32'h0002_0000, 32'h0000_FFFF,
			32'h0021_0000, 32'hFFFE_8000};
		foreach (cat_vals[k]) begin
			put_feature(6, cat_vals[k]);
			classify(0);
		end
		// Self loop on the root runs into the walk limit.
		put_node(0, 0, 0, 0, 1, 0, 0, 'h55);
		classify(0);

		// Register settings, extremes first, then random ones.
		idle_on = 1'b1;
		for (int ph = 0; ph < 8; ph++) begin
			logic [5:0] pv;
			logic       pe;
			case (ph)
				0: begin pv = 6'd0;  pe = 1'b0; end
				1: begin pv = 6'd63; pe = 1'b1; end
				2: begin pv = 6'd0;  pe = 1'b1; end
				default: begin pv = 6'($urandom); pe = $urandom_range(0, 3) != 0; end
			endcase
			write_reg(32'(dtc_pkg::REG_PERMUTE_VAR), {26'h0, pv});
			write_reg(32'(dtc_pkg::REG_PERMUTE_ENABLE), {31'h0, pe});
			if (ph == 2) begin
				// Keep offering work while the receiver holds off, so the queue backs up.
				long_hold = 1'b1;
				repeat (20) classify(pick_q());
			end
			if (ph == 7)
				idle_on = 1'b0;
			random_phase(ph == 7 ? 120 : 80);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d transfers, %0d walks (%0d bad category, %0d walk limit)",
			n_items, n_walks, n_bad_cat, n_limit);
		if (errors == 0)
			$display("** decision_tree_classify_permuted_top: PASSED **");
		else
			$display("** decision_tree_classify_permuted_top: FAILED **");
		$finish;
	end
endmodule
